// ===== src/m3i_pkg.sv =====
// ---------------------------------------------------------------------------
// m3i_pkg: shared types and constants for the 3x3 matrix inverse
// Payload structs, datapath widths and pipeline depths used by every module.
// ---------------------------------------------------------------------------
`default_nettype none
package m3i_pkg;

	// fraction bits of the input entries; the quotient is scaled by 2^OUT_SHIFT
	localparam int IN_FRAC_BITS = 8;
	localparam int OUT_SHIFT    = IN_FRAC_BITS + 16;

	localparam int ENT_W   = 16;            // input entry
	localparam int PROD_W  = 2 * ENT_W;     // 2x2 minor product
	localparam int COF_W   = PROD_W + 1;    // cofactor, signed
	localparam int DET_W   = COF_W + ENT_W; // determinant, signed
	localparam int MC_W    = COF_W - 1;     // cofactor magnitude
	localparam int MD_W    = DET_W - 1;     // determinant magnitude
	localparam int Q_W     = 32;            // quotient bits before saturation
	localparam int LANES   = 9;

	localparam int COF_LAT = 4;             // cofactor and determinant stages
	localparam int DIV_LAT = Q_W + 1;       // operand set-up plus one bit a stage

	localparam logic [Q_W-1:0] POS_MAX = {1'b0, {(Q_W-1){1'b1}}};
	localparam logic [Q_W-1:0] NEG_MIN = {1'b1, {(Q_W-1){1'b0}}};

	typedef struct packed {
		logic signed [ENT_W-1:0] a00;
		logic signed [ENT_W-1:0] a01;
		logic signed [ENT_W-1:0] a02;
		logic signed [ENT_W-1:0] a10;
		logic signed [ENT_W-1:0] a11;
		logic signed [ENT_W-1:0] a12;
		logic signed [ENT_W-1:0] a20;
		logic signed [ENT_W-1:0] a21;
		logic signed [ENT_W-1:0] a22;
	} mat_t;

	typedef struct packed {
		logic signed [Q_W-1:0] b00;
		logic signed [Q_W-1:0] b01;
		logic signed [Q_W-1:0] b02;
		logic signed [Q_W-1:0] b10;
		logic signed [Q_W-1:0] b11;
		logic signed [Q_W-1:0] b12;
		logic signed [Q_W-1:0] b20;
		logic signed [Q_W-1:0] b21;
		logic signed [Q_W-1:0] b22;
		logic                  singular;
	} inv_t;

	// quotient result of one divide lane
	typedef struct packed {
		logic [Q_W-1:0] q;
		logic           ovf;
		logic           neg;
	} quo_t;

endpackage
`default_nettype wire

// ===== src/matrix3x3_inverse_top.sv =====
// ---------------------------------------------------------------------------
// matrix3x3_inverse_top: 3x3 inverse by adjugate over determinant
// Cofactor pipeline, nine divide lanes side by side, saturating merge stage.
// ---------------------------------------------------------------------------
// Channel | Signals                 | Payload
// mat     | mat_valid, mat_ready    | mat_t: a00..a22, signed Q8.8
// inv     | inv_valid, inv_ready    | inv_t: b00..b22 signed Q16.16, singular
//
// One matrix is taken every cycle unless a result waits untaken; each result
// passes 4 cofactor stages, 33 divider stages and 1 output register.
// The latency is set by the bit-per-stage divider in each lane.
// The whole pipeline advances together and holds while a result waits
// untaken; mat_ready is low only then.
// Reset clears the stage valid bits and the output valid.
// ---------------------------------------------------------------------------
`default_nettype none
module matrix3x3_inverse_top (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           mat_valid,
	output logic                mat_ready,
	input  wire m3i_pkg::mat_t  mat,
	output logic                inv_valid,
	input  wire logic           inv_ready,
	output m3i_pkg::inv_t       inv
);
	import m3i_pkg::*;

	localparam int PIPE = COF_LAT + DIV_LAT;

	logic                    en;
	logic signed [COF_W-1:0] cof [0:8];
	logic signed [DET_W-1:0] det;
	quo_t                    quo [0:LANES-1];
	logic [PIPE-1:0]         vld_s;
	logic [DIV_LAT-1:0]      sing_s;
	logic [Q_W-1:0]          res [0:LANES-1];
	logic                    inv_valid_q;
	inv_t                    inv_q;

	function automatic logic [Q_W-1:0] sat_q(input quo_t x);
		logic [Q_W-1:0] r;
		if (x.neg) begin
			r = (x.ovf || x.q > NEG_MIN) ? NEG_MIN : Q_W'(-x.q);
		end else begin
			r = (x.ovf || x.q > POS_MAX) ? POS_MAX : x.q;
		end
		return r;
	endfunction

	// advance whenever the output register is free or being taken
	assign en        = !inv_valid_q || inv_ready;
	assign mat_ready = en;

	m3i_cofactor u_cof (
		.clk (clk),
		.en  (en),
		.mat (mat),
		.cof (cof),
		.det (det)
	);

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		m3i_div_lane u_div (
			.clk (clk),
			.en  (en),
			.cof (cof[l]),
			.det (det),
			.quo (quo[l])
		);
		assign res[l] = sat_q(quo[l]);
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[PIPE-2:0], mat_valid};
		end
	end

	// carry the zero-determinant flag alongside the lanes
	always_ff @(posedge clk) begin
		if (en) begin
			sing_s <= {sing_s[DIV_LAT-2:0], det == '0};
		end
	end

	// merge: saturate each lane, force zeros when singular
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_valid_q <= 1'b0;
		end else if (en) begin
			inv_valid_q <= vld_s[PIPE-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sing_s[DIV_LAT-1]) begin
				inv_q.b00      <= '0;
				inv_q.b01      <= '0;
				inv_q.b02      <= '0;
				inv_q.b10      <= '0;
				inv_q.b11      <= '0;
				inv_q.b12      <= '0;
				inv_q.b20      <= '0;
				inv_q.b21      <= '0;
				inv_q.b22      <= '0;
				inv_q.singular <= 1'b1;
			end else begin
				inv_q.b00      <= res[0];
				inv_q.b01      <= res[1];
				inv_q.b02      <= res[2];
				inv_q.b10      <= res[3];
				inv_q.b11      <= res[4];
				inv_q.b12      <= res[5];
				inv_q.b20      <= res[6];
				inv_q.b21      <= res[7];
				inv_q.b22      <= res[8];
				inv_q.singular <= 1'b0;
			end
		end
	end

	assign inv_valid = inv_valid_q;
	assign inv       = inv_q;

endmodule
`default_nettype wire

// ===== src/m3i_cofactor.sv =====
// ---------------------------------------------------------------------------
// m3i_cofactor: adjugate and determinant pipeline
// Four stages: minor products, cofactors, row-0 products, determinant sum.
// ---------------------------------------------------------------------------
`default_nettype none
module m3i_cofactor (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire m3i_pkg::mat_t              mat,
	output logic signed [m3i_pkg::COF_W-1:0] cof [0:8],
	output logic signed [m3i_pkg::DET_W-1:0] det
);
	import m3i_pkg::*;

	logic signed [PROD_W-1:0] p_s1 [0:17];
	logic signed [ENT_W-1:0]  r0_s1 [0:2];
	logic signed [ENT_W-1:0]  r0_s2 [0:2];
	logic signed [COF_W-1:0]  c_s2 [0:8];
	logic signed [COF_W-1:0]  c_s3 [0:8];
	logic signed [DET_W-1:0]  t_s3 [0:2];
	logic signed [COF_W-1:0]  c_s4 [0:8];
	logic signed [DET_W-1:0]  det_s4;

	// stage 1: the eighteen minor products, adjugate order
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0]  <= mat.a11 * mat.a22;  p_s1[1]  <= mat.a21 * mat.a12;
			p_s1[2]  <= mat.a02 * mat.a21;  p_s1[3]  <= mat.a01 * mat.a22;
			p_s1[4]  <= mat.a01 * mat.a12;  p_s1[5]  <= mat.a02 * mat.a11;
			p_s1[6]  <= mat.a12 * mat.a20;  p_s1[7]  <= mat.a10 * mat.a22;
			p_s1[8]  <= mat.a00 * mat.a22;  p_s1[9]  <= mat.a02 * mat.a20;
			p_s1[10] <= mat.a10 * mat.a02;  p_s1[11] <= mat.a00 * mat.a12;
			p_s1[12] <= mat.a10 * mat.a21;  p_s1[13] <= mat.a20 * mat.a11;
			p_s1[14] <= mat.a20 * mat.a01;  p_s1[15] <= mat.a00 * mat.a21;
			p_s1[16] <= mat.a00 * mat.a11;  p_s1[17] <= mat.a10 * mat.a01;
			r0_s1[0] <= mat.a00;
			r0_s1[1] <= mat.a01;
			r0_s1[2] <= mat.a02;
		end
	end

	// stage 2: cofactors as product differences
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++) begin
				c_s2[i] <= COF_W'(p_s1[2*i]) - COF_W'(p_s1[2*i+1]);
			end
			r0_s2 <= r0_s1;
		end
	end

	// stage 3: row-0 expansion products
	always_ff @(posedge clk) begin
		if (en) begin
			t_s3[0] <= DET_W'(r0_s2[0]) * DET_W'(c_s2[0]);
			t_s3[1] <= DET_W'(r0_s2[1]) * DET_W'(c_s2[3]);
			t_s3[2] <= DET_W'(r0_s2[2]) * DET_W'(c_s2[6]);
			c_s3    <= c_s2;
		end
	end

	// stage 4: determinant sum, bounded well inside DET_W
	always_ff @(posedge clk) begin
		if (en) begin
			det_s4 <= t_s3[0] + t_s3[1] + t_s3[2];
			c_s4   <= c_s3;
		end
	end

	assign cof = c_s4;
	assign det = det_s4;

endmodule
`default_nettype wire

// ===== src/m3i_div_lane.sv =====
// ---------------------------------------------------------------------------
// m3i_div_lane: pipelined restoring divider for one inverse entry
// Forms |cof| * 2^OUT_SHIFT / |det|, one quotient bit a stage, with overflow.
// ---------------------------------------------------------------------------
`default_nettype none
module m3i_div_lane (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic signed [m3i_pkg::COF_W-1:0] cof,
	input  wire logic signed [m3i_pkg::DET_W-1:0] det,
	output m3i_pkg::quo_t                    quo
);
	import m3i_pkg::*;

	localparam int NW = MC_W + OUT_SHIFT;

	logic [MC_W-1:0] mc;
	logic [MD_W-1:0] md;
	logic [NW-1:0]   num;
	logic [OUT_SHIFT-1:0] hi;

	logic [MD_W-1:0] rem_s [0:Q_W];
	logic [MD_W-1:0] md_s  [0:Q_W];
	logic [Q_W-1:0]  low_s [0:Q_W];
	logic [Q_W-1:0]  q_s   [0:Q_W];
	logic            ovf_s [0:Q_W];
	logic            neg_s [0:Q_W];

	// take magnitudes and scale the dividend
	always_comb begin
		mc  = cof[COF_W-1] ? MC_W'(-cof) : MC_W'(cof);
		md  = det[DET_W-1] ? MD_W'(-det) : MD_W'(det);
		num = {mc, {OUT_SHIFT{1'b0}}};
		hi  = num[NW-1:Q_W];
	end

	// set-up stage: quotient reaches 2^Q_W when the top part is not below the divisor
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= MD_W'(hi);
			md_s[0]  <= md;
			low_s[0] <= num[Q_W-1:0];
			q_s[0]   <= '0;
			ovf_s[0] <= {{(MD_W-OUT_SHIFT){1'b0}}, hi} >= md;
			neg_s[0] <= cof[COF_W-1] ^ det[DET_W-1];
		end
	end

	// one quotient bit per stage
	for (genvar k = 0; k < Q_W; k++) begin : g_step
		logic [MD_W:0] trial;
		logic [MD_W:0] diff;

		assign trial = {rem_s[k], low_s[k][Q_W-1]};
		assign diff  = trial - {1'b0, md_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				if (!diff[MD_W]) begin
					rem_s[k+1] <= diff[MD_W-1:0];
					q_s[k+1]   <= {q_s[k][Q_W-2:0], 1'b1};
				end else begin
					rem_s[k+1] <= trial[MD_W-1:0];
					q_s[k+1]   <= {q_s[k][Q_W-2:0], 1'b0};
				end
				md_s[k+1]  <= md_s[k];
				low_s[k+1] <= {low_s[k][Q_W-2:0], 1'b0};
				ovf_s[k+1] <= ovf_s[k];
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	assign quo.q   = q_s[Q_W];
	assign quo.ovf = ovf_s[Q_W];
	assign quo.neg = neg_s[Q_W];

endmodule
`default_nettype wire

// ===== src/m3i_checker.sv =====
// ---------------------------------------------------------------------------
// m3i_checker: port-level checks for the matrix inverse
// Watches the handshakes and the singular result encoding.
// ---------------------------------------------------------------------------
`default_nettype none
module m3i_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          mat_valid,
	input wire logic          mat_ready,
	input wire m3i_pkg::mat_t mat,
	input wire logic          inv_valid,
	input wire logic          inv_ready,
	input wire m3i_pkg::inv_t inv
);
	import m3i_pkg::*;

	// hold a waiting input transfer
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mat_valid && !mat_ready |=> mat_valid && $stable(mat))
		else $error("input changed while waiting");

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		inv_valid && !inv_ready |=> inv_valid && $stable(inv))
		else $error("result changed while stalled");

	// an empty output never blocks input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!inv_valid |-> mat_ready)
		else $error("input blocked with output empty");

	// a stalled output stops the pipeline
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		inv_valid && !inv_ready |-> !mat_ready)
		else $error("input taken while output stalled");

	// singular results carry zeros in b00, b01, b11, b12, b20 and b22
	a_sing: assert property (@(posedge clk) disable iff (!arst_n)
		inv_valid && inv.singular |-> inv.b00 == 0 && inv.b11 == 0 && inv.b22 == 0
			&& inv.b01 == 0 && inv.b12 == 0 && inv.b20 == 0)
		else $error("singular result with nonzero entries");

endmodule

bind matrix3x3_inverse_top m3i_checker u_m3i_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.mat_valid (mat_valid),
	.mat_ready (mat_ready),
	.mat       (mat),
	.inv_valid (inv_valid),
	.inv_ready (inv_ready),
	.inv       (inv)
);
`default_nettype wire

// ===== dv/tb_matrix3x3_inverse_top.sv =====
// ---------------------------------------------------------------------------
// tb_matrix3x3_inverse_top: self-checking bench for the 3x3 matrix inverse
// Sends Q8.8 matrices over the mat channel, predicts each Q16.16 inverse with
// an exact cofactor/determinant model and compares every field of the result.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_matrix3x3_inverse_top;
	import m3i_pkg::*;

	localparam int WDOG_LIMIT = 20000;

	logic  clk;
	logic  arst_n;
	logic  mat_valid;
	logic  mat_ready;
	mat_t  mat;
	logic  inv_valid;
	logic  inv_ready;
	inv_t  inv;

	inv_t  inverse_q[$];
	int    err_cnt;
	int    sent_cnt;
	int    rcvd_cnt;
	int    sing_cnt;
	int    sat_cnt;
	int    idle_pct;
	int    stall_pct;
	int    wdog;

	matrix3x3_inverse_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.mat_valid (mat_valid),
		.mat_ready (mat_ready),
		.mat       (mat),
		.inv_valid (inv_valid),
		.inv_ready (inv_ready),
		.inv       (inv)
	);

	// free-running clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// truncating divide of cof * 2^OUT_SHIFT by det, saturated to 32 bits
	function automatic logic [31:0] quot_sat(longint cof, longint det);
		logic        neg;
		logic [63:0] mc;
		logic [63:0] md;
		logic [63:0] q;
		neg = (cof < 0) != (det < 0);
		mc  = (cof < 0) ? 64'(-cof) : 64'(cof);
		md  = (det < 0) ? 64'(-det) : 64'(det);
		q   = (mc << OUT_SHIFT) / md;
		if (neg) begin
			if (q > 64'h8000_0000)
				q = 64'h8000_0000;
			return 32'(-q);
		end
		if (q > 64'h7FFF_FFFF)
			q = 64'h7FFF_FFFF;
		return q[31:0];
	endfunction

	// adjugate over determinant, expansion along row 0
	function automatic inv_t inverse_of(mat_t m);
		longint  c[9];
		longint  det;
		logic [31:0] b[9];
		inv_t    r;
		c[0] = longint'(m.a11) * m.a22 - longint'(m.a21) * m.a12;
		c[1] = longint'(m.a02) * m.a21 - longint'(m.a01) * m.a22;
		c[2] = longint'(m.a01) * m.a12 - longint'(m.a02) * m.a11;
		c[3] = longint'(m.a12) * m.a20 - longint'(m.a10) * m.a22;
		c[4] = longint'(m.a00) * m.a22 - longint'(m.a02) * m.a20;
		c[5] = longint'(m.a10) * m.a02 - longint'(m.a00) * m.a12;
		c[6] = longint'(m.a10) * m.a21 - longint'(m.a20) * m.a11;
		c[7] = longint'(m.a20) * m.a01 - longint'(m.a00) * m.a21;
		c[8] = longint'(m.a00) * m.a11 - longint'(m.a10) * m.a01;
		det  = longint'(m.a00) * c[0] + longint'(m.a01) * c[3] + longint'(m.a02) * c[6];
		for (int k = 0; k < 9; k++)
			b[k] = (det == 0) ? 32'd0 : quot_sat(c[k], det);
		r.b00 = b[0]; r.b01 = b[1]; r.b02 = b[2];
		r.b10 = b[3]; r.b11 = b[4]; r.b12 = b[5];
		r.b20 = b[6]; r.b21 = b[7]; r.b22 = b[8];
		r.singular = (det == 0);
		return r;
	endfunction

	// drive one matrix and hold it until the transfer; drop valid only to idle
	task automatic send_matrix(mat_t m);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			mat_valid <= 1'b0;
			@(negedge clk);
		end
		mat       <= m;
		mat_valid <= 1'b1;
		inverse_q.push_back(inverse_of(m));
		@(posedge clk);
		while (!mat_ready)
			@(posedge clk);
		sent_cnt++;
		@(negedge clk);
	endtask

	function automatic mat_t mk(int v0, int v1, int v2, int v3, int v4,
			int v5, int v6, int v7, int v8);
		mat_t m;
		m = {16'(v0), 16'(v1), 16'(v2), 16'(v3), 16'(v4),
			16'(v5), 16'(v6), 16'(v7), 16'(v8)};
		return m;
	endfunction

	function automatic logic [15:0] rand_entry();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom_range(4) - 2);
			3: return 16'(int'($urandom_range(1024)) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	// random matrix: full range, near-singular, singular by repeated row
	function automatic mat_t rand_matrix();
		mat_t m;
		m = {rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry(),
			rand_entry(), rand_entry(), rand_entry(), rand_entry()};
		case ($urandom_range(9))
			0: begin
				m.a20 = m.a10; m.a21 = m.a11; m.a22 = m.a12;
			end
			1: begin
				m.a01 = 0; m.a02 = 0; m.a10 = 0; m.a12 = 0; m.a20 = 0; m.a21 = 0;
				m.a00 = 16'($urandom_range(3)); m.a11 = 16'($urandom_range(3));
			end
			default: ;
		endcase
		return m;
	endfunction

	// compare each result with the oldest prediction
	always @(posedge clk) begin
		if (inv_valid && inv_ready) begin
			if (inverse_q.size() == 0) begin
				$error("unexpected result transfer");
				err_cnt++;
			end else begin
				inv_t e;
				e = inverse_q.pop_front();
				rcvd_cnt++;
				if (e.singular)
					sing_cnt++;
				if (e.b00 == POS_MAX || e.b00 == NEG_MIN)
					sat_cnt++;
				if (inv.b00 !== e.b00) begin $error("b00 exp %h got %h", e.b00, inv.b00); err_cnt++; end
				if (inv.b01 !== e.b01) begin $error("b01 exp %h got %h", e.b01, inv.b01); err_cnt++; end
				if (inv.b02 !== e.b02) begin $error("b02 exp %h got %h", e.b02, inv.b02); err_cnt++; end
				if (inv.b10 !== e.b10) begin $error("b10 exp %h got %h", e.b10, inv.b10); err_cnt++; end
				if (inv.b11 !== e.b11) begin $error("b11 exp %h got %h", e.b11, inv.b11); err_cnt++; end
				if (inv.b12 !== e.b12) begin $error("b12 exp %h got %h", e.b12, inv.b12); err_cnt++; end
				if (inv.b20 !== e.b20) begin $error("b20 exp %h got %h", e.b20, inv.b20); err_cnt++; end
				if (inv.b21 !== e.b21) begin $error("b21 exp %h got %h", e.b21, inv.b21); err_cnt++; end
				if (inv.b22 !== e.b22) begin $error("b22 exp %h got %h", e.b22, inv.b22); err_cnt++; end
				if (inv.singular !== e.singular) begin
					$error("singular exp %b got %b", e.singular, inv.singular);
					err_cnt++;
				end
			end
		end
	end

	// randomise the result stall
	always @(negedge clk)
		inv_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

	// end the run when no transfer happens for too long
	always @(posedge clk) begin
		if ((mat_valid && mat_ready) || (inv_valid && inv_ready))
			wdog <= 0;
		else if (arst_n && wdog + 1 >= WDOG_LIMIT) begin
			$display("watchdog expired");
			$display("DONE: errors detected");
			$finish;
		end else if (arst_n)
			wdog <= wdog + 1;
	end

	task automatic test_directed();
		send_matrix(mk(256, 0, 0, 0, 256, 0, 0, 0, 256));          // identity
		send_matrix(mk(512, 0, 0, 0, -256, 0, 0, 0, 128));
		send_matrix(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));                // zero matrix
		send_matrix(mk(256, 512, 768, 256, 512, 768, 1, 2, 3));    // singular rows
		send_matrix(mk(1, 0, 0, 0, 1, 0, 0, 0, 1));                // tiny det
		send_matrix(mk(-1, 0, 0, 0, 1, 0, 0, 0, 1));               // tiny det, negative
		send_matrix(mk(32767, 0, 0, 0, 32767, 0, 0, 0, 32767));
		send_matrix(mk(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768));
		send_matrix(mk(-32768, -32768, -32768, -32768, 32767, -32768,
			-32768, -32768, 32767));
		send_matrix(mk(32767, -32768, 32767, -32768, 32767, -32768,
			32767, 32767, -32768));
		send_matrix(mk(0, 256, 0, 256, 0, 0, 0, 0, 256));          // permutation
		send_matrix(mk(256, 128, -64, 3, 700, 9, -5, 40, 1000));
		send_matrix(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1));
		send_matrix(mk(2, 1, 0, 1, 2, 1, 0, 1, 2));
	endtask

	task automatic test_random(int n, int idle, int stall);
		idle_pct  = idle;
		stall_pct = stall;
		for (int i = 0; i < n; i++)
			send_matrix(rand_matrix());
	endtask

	task automatic drain();
		mat_valid <= 1'b0;
		while (inverse_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		arst_n    = 1'b0;
		mat_valid = 1'b0;
		mat       = '0;
		inv_ready = 1'b0;
		err_cnt = 0; sent_cnt = 0; rcvd_cnt = 0; sing_cnt = 0; sat_cnt = 0;
		idle_pct = 0; stall_pct = 0; wdog = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random(250, 0, 0);
		test_random(250, 54, 0);
		test_random(250, 0, 54);
		test_random(250, 31, 31);
		idle_pct = 0; stall_pct = 0;
		drain();
		$display("Covered %0d matrices, %0d results, %0d singular, %0d saturated b00.",
			sent_cnt, rcvd_cnt, sing_cnt, sat_cnt);
		$display("Idle and stall phases: none, sender 54%%, receiver 54%%, both 31%%.");
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire

// ===== matrix3x3_inverse_top.f =====
src/m3i_pkg.sv
src/m3i_cofactor.sv
src/m3i_div_lane.sv
src/matrix3x3_inverse_top.sv
src/m3i_checker.sv
dv/tb_matrix3x3_inverse_top.sv
